FILE: hw/rtl/assert_macros.svh
// Assertion macros for the checker file of the glyph rasterizer.
// They expect clk and arst_n in the scope that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define GR8_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define GR8_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/gr8_pkg.sv
// Package of the glyph rasterizer: types, register indexes, reset values, font ROM.
// Used by every module of the block but gr8_checker; depends on nothing.
`timescale 1ns / 1ps

package gr8_pkg;

	localparam int FONT_CHARS = 128;

	localparam int PosW    = 16;
	localparam int CodeW   = 8;
	localparam int ColorW  = 32;
	localparam int IndexW  = 25;
	localparam int WidthW  = 13;
	localparam int HeightW = 13;
	localparam int PitchW  = 14;
	localparam int CfgW    = 14;
	localparam int CoordW  = PosW + 1;
	localparam int GlyphW  = 64;
	localparam int BitIdxW = 6;

	localparam logic [WidthW-1:0]  WidthReset  = 13'd640;
	localparam logic [HeightW-1:0] HeightReset = 13'd480;
	localparam logic [PitchW-1:0]  PitchReset  = 14'd640;

	typedef enum logic [1:0] {
		REG_SCREEN_WIDTH  = 2'd0,
		REG_SCREEN_HEIGHT = 2'd1,
		REG_LINE_PITCH    = 2'd2
	} cfg_reg_t;

	// One character after clipping: bit row*8+col set for every visible pixel.
	typedef struct packed {
		logic [GlyphW-1:0] mask;
		logic [PosW-1:0]   pos_x;
		logic [PosW-1:0]   pos_y;
		logic [ColorW-1:0] color;
	} item_t;

	// Glyph bitmap, row r in bits [8r+7:8r], column 0 at the high bit of each byte.
	function automatic logic [GlyphW-1:0] font_glyph(input logic [CodeW-1:0] code);
		logic [GlyphW-1:0] g;
		g = '0;
		if ({1'b0, code} < 9'(FONT_CHARS)) begin
			case (code)
				8'h48: g = 64'h00424242_7E424242; // H
				8'h41: g = 64'h0042427E_42422418; // A
				8'h43: g = 64'h003C4240_4040423C; // C
				8'h4F: g = 64'h003C4242_4242423C; // O
				8'h53: g = 64'h003C4202_3C40423C; // S
				8'h21: g = 64'h00080008_08080808; // !
				8'h30: g = 64'h003C4262_524A463C;
				8'h31: g = 64'h001C0808_08081808;
				8'h32: g = 64'h007E4030_0C02423C;
				8'h33: g = 64'h003C4202_1C02423C;
				8'h34: g = 64'h0004047E_24140C04;
				8'h35: g = 64'h003C4202_027C407E;
				8'h36: g = 64'h003C4242_7C40201C;
				8'h37: g = 64'h00101010_0804027E;
				8'h38: g = 64'h003C4242_3C42423C;
				8'h39: g = 64'h00380402_3E42423C;
				8'h78: g = 64'h00422418_24420000; // x
				8'h2E: g = 64'h00080000_00000000; // .
				8'h3A: g = 64'h00000800_00080000; // :
				default: g = '0;
			endcase
		end
		return g;
	endfunction

endpackage

FILE: hw/rtl/glyph_rasterizer_8x8.sv
// An accepted request passes the queue, the current-character registers, stage 1, stage 2
// and the output register before its first pixel write. Throughput: one pixel write per
// cycle unless m_axis_tready stalls, one per set bit of a character's clipped mask (up to 64).
// Blank or fully clipped characters produce no writes; requests enter while writes drain.
// Reset: registers return to width 640, height 480, pitch 640; queue and pipeline empty.
`timescale 1ns / 1ps

module glyph_rasterizer_8x8 (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [gr8_pkg::CfgW-1:0]    cfg_data,
	// pos_x[15:0], pos_y[31:16], char_code[39:32], color[71:40]
	input  logic [71:0]                 s_axis_tdata,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// pixel_index[24:0], pixel_color[56:25], zero[63:57]
	output logic [63:0]                 m_axis_tdata,
	output logic                        m_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready
);

	logic [gr8_pkg::WidthW-1:0]  screen_width_q;
	logic [gr8_pkg::HeightW-1:0] screen_height_q;
	logic [gr8_pkg::PitchW-1:0]  line_pitch_q;

	logic           q_full;
	logic           push;
	gr8_pkg::item_t push_item;
	logic           pop;
	logic           head_valid;
	gr8_pkg::item_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= gr8_pkg::WidthReset;
			screen_height_q <= gr8_pkg::HeightReset;
			line_pitch_q    <= gr8_pkg::PitchReset;
		end else if (cfg_we) begin
			case (cfg_index)
				gr8_pkg::REG_SCREEN_WIDTH:
					screen_width_q <= cfg_data[gr8_pkg::WidthW-1:0];
				gr8_pkg::REG_SCREEN_HEIGHT:
					screen_height_q <= cfg_data[gr8_pkg::HeightW-1:0];
				gr8_pkg::REG_LINE_PITCH:
					line_pitch_q <= cfg_data;
				default: ;
			endcase
		end
	end

	gr8_front u_front (
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.screen_width  (screen_width_q),
		.screen_height (screen_height_q),
		.q_full        (q_full),
		.push          (push),
		.push_item     (push_item)
	);

	gr8_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	gr8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.line_pitch    (line_pitch_q),
		.head_valid    (head_valid),
		.head_item     (head_item),
		.pop           (pop),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready)
	);

endmodule

FILE: hw/rtl/gr8_front.sv
// Front end: decode a character request, look up its glyph and clip it to the screen.
// Depends on gr8_pkg; feeds gr8_queue.
`timescale 1ns / 1ps

module gr8_front (
	input  logic [71:0]                  s_axis_tdata,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [gr8_pkg::WidthW-1:0]   screen_width,
	input  logic [gr8_pkg::HeightW-1:0]  screen_height,
	input  logic                         q_full,
	output logic                         push,
	output gr8_pkg::item_t               push_item
);

	logic [gr8_pkg::PosW-1:0]   pos_x;
	logic [gr8_pkg::PosW-1:0]   pos_y;
	logic [gr8_pkg::CodeW-1:0]  char_code;
	logic [gr8_pkg::GlyphW-1:0] glyph;
	logic [7:0]                 row_vis;
	logic [7:0]                 col_vis;
	logic [gr8_pkg::GlyphW-1:0] mask;

	assign pos_x     = s_axis_tdata[15:0];
	assign pos_y     = s_axis_tdata[31:16];
	assign char_code = s_axis_tdata[39:32];
	assign glyph     = gr8_pkg::font_glyph(char_code);

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			row_vis[i] = ({1'b0, pos_y} + gr8_pkg::CoordW'(i))
				< gr8_pkg::CoordW'(screen_height);
			col_vis[i] = ({1'b0, pos_x} + gr8_pkg::CoordW'(i))
				< gr8_pkg::CoordW'(screen_width);
		end
		for (int r = 0; r < 8; r++) begin
			for (int c = 0; c < 8; c++) begin
				mask[r*8 + c] = glyph[r*8 + 7 - c] & row_vis[r] & col_vis[c];
			end
		end
	end

	assign s_axis_tready = !q_full;

	// Drop requests that leave nothing on screen.
	assign push = s_axis_tvalid && !q_full && (mask != '0);

	assign push_item.mask  = mask;
	assign push_item.pos_x = pos_x;
	assign push_item.pos_y = pos_y;
	assign push_item.color = s_axis_tdata[71:40];

endmodule

FILE: hw/rtl/gr8_queue.sv
// Two-entry queue of clipped characters between front end and pixel walker.
// Depends on gr8_pkg.
`timescale 1ns / 1ps

module gr8_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gr8_pkg::item_t push_item,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output gr8_pkg::item_t head_item
);

	gr8_pkg::item_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_item;
	end

endmodule

FILE: hw/rtl/gr8_back.sv
// Back end: walk the visible pixels of one character a cycle at a time unless the
// output stalls, and form writes. Depends on gr8_pkg; takes characters from gr8_queue.
`timescale 1ns / 1ps

module gr8_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gr8_pkg::PitchW-1:0]  line_pitch,
	input  logic                        head_valid,
	input  gr8_pkg::item_t              head_item,
	output logic                        pop,
	output logic [63:0]                 m_axis_tdata,
	output logic                        m_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready
);

	// Current character
	logic [gr8_pkg::GlyphW-1:0] mask_q;
	logic [gr8_pkg::PosW-1:0]   pos_x_q;
	logic [gr8_pkg::PosW-1:0]   pos_y_q;
	logic [gr8_pkg::ColorW-1:0] color_q;
	logic                       cur_valid_q;

	logic                        en;
	logic [gr8_pkg::GlyphW-1:0]  pick;
	logic [gr8_pkg::GlyphW-1:0]  mask_next;
	logic [gr8_pkg::BitIdxW-1:0] bit_idx;
	logic                        last_pick;

	// Stage 1: pixel coordinates
	logic                        valid_s1;
	logic [gr8_pkg::CoordW-1:0]  x_s1;
	logic [gr8_pkg::CoordW-1:0]  y_s1;
	logic [gr8_pkg::ColorW-1:0]  color_s1;
	logic                        last_s1;

	// Stage 2: row offset
	logic                        valid_s2;
	logic [gr8_pkg::CoordW-1:0]  x_s2;
	logic [gr8_pkg::IndexW-1:0]  row_off_s2;
	logic [gr8_pkg::ColorW-1:0]  color_s2;
	logic                        last_s2;
	logic [gr8_pkg::CoordW+gr8_pkg::PitchW-1:0] product;

	// Output register
	logic                        valid_q;
	logic [gr8_pkg::IndexW-1:0]  index_q;
	logic [gr8_pkg::ColorW-1:0]  out_color_q;
	logic                        last_q;

	assign en = !valid_q || m_axis_tready;

	// Lowest set bit comes first: rows top down, columns left to right.
	assign pick      = mask_q & (~mask_q + gr8_pkg::GlyphW'(1));
	assign mask_next = mask_q & ~pick;
	assign last_pick = (mask_next == '0);

	always_comb begin
		bit_idx = '0;
		for (int k = 0; k < gr8_pkg::GlyphW; k++) begin
			if (pick[k]) bit_idx = bit_idx | gr8_pkg::BitIdxW'(k);
		end
	end

	assign pop = head_valid && (!cur_valid_q || (en && last_pick));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
		end else if (pop) begin
			cur_valid_q <= 1'b1;
		end else if (en && last_pick) begin
			cur_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mask_q  <= head_item.mask;
			pos_x_q <= head_item.pos_x;
			pos_y_q <= head_item.pos_y;
			color_q <= head_item.color;
		end else if (en && cur_valid_q) begin
			mask_q <= mask_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_q  <= 1'b0;
		end else if (en) begin
			valid_s1 <= cur_valid_q;
			valid_s2 <= valid_s1;
			valid_q  <= valid_s2;
		end
	end

	assign product = y_s1 * line_pitch;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= {1'b0, pos_x_q} + gr8_pkg::CoordW'(bit_idx[2:0]);
			y_s1     <= {1'b0, pos_y_q} + gr8_pkg::CoordW'(bit_idx[5:3]);
			color_s1 <= color_q;
			last_s1  <= last_pick;

			x_s2       <= x_s1;
			row_off_s2 <= product[gr8_pkg::IndexW-1:0];
			color_s2   <= color_s1;
			last_s2    <= last_s1;

			index_q     <= row_off_s2 + gr8_pkg::IndexW'(x_s2);
			out_color_q <= color_s2;
			last_q      <= last_s2;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tdata  = {7'd0, out_color_q, index_q};

endmodule

FILE: hw/rtl/gr8_checker.sv
// Port-level checks of the glyph rasterizer, bound to its top level.
// Depends on assert_macros.svh and glyph_rasterizer_8x8.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gr8_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [63:0] m_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready
);

	`GR8_ASSERT_NEXT(a_out_valid_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "write request dropped while stalled")
	`GR8_ASSERT_NEXT(a_out_data_hold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "write payload changed while stalled")
	`GR8_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[63:57] == 7'd0, "padding bits of write data not zero")
	`GR8_ASSERT_NOW(a_ready_fall, $fell(s_axis_tready), $past(s_axis_tvalid), "input ready fell without a request to fill the queue")

endmodule

bind glyph_rasterizer_8x8 gr8_checker u_gr8_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready)
);
